// ===== design/bld_pkg.sv =====
// Shared types and codes for the bounded key list and its cell chain.
`timescale 1ns / 1ps

package bld_pkg;

	localparam int KEY_W    = 32;
	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 3;

	// Operation codes on the input tuser
	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT    = 3'd0,
		FN_DEL_KEY   = 3'd1,
		FN_DEL_FIRST = 3'd2,
		FN_DEL_LAST  = 3'd3,
		FN_DUMP      = 3'd4
	} func_t;

	// Result codes on the output tuser
	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 3'd0,
		STS_NOT_FOUND = 3'd1,
		STS_EMPTY     = 3'd2,
		STS_FULL      = 3'd3,
		STS_ENTRY     = 3'd4
	} status_t;

	// What every cell of the chain does this cycle
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_REMOVE,
		CELL_TRIM,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [KEY_W-1:0]  key;
	} cell_ctl_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP
	} fsm_t;

endpackage

// ===== design/bounded_list_with_key_delete_unit.sv =====
// Top level: bounded ordered key list built as a chain of shifting cells.
`timescale 1ns / 1ps
//
// Usage
//   Input channel s_*: one item per operation. s_tuser[2:0] is the operation
//   (insert, delete by key, delete first, delete last, dump), s_tdata[31:0]
//   the signed key. Output channel m_*: m_tuser[2:0] is the status,
//   m_tdata[31:0] the dumped key (zero otherwise), m_tlast marks the last
//   result of an operation.
//   The list lives in CAPACITY cells; entry 0 is the front. Insert, delete
//   and trim update all cells together; delete by key finds the first
//   match through a hit chain that ripples from the front cell.
//   Sequencing: an item is taken in S_IDLE and executed in S_EXEC; once the
//   output register is free the result is written to it and S_IDLE resumes,
//   so a new item is only taken after the previous one has left S_EXEC. A
//   dump then enters S_DUMP: the chain rotates one place per cycle while the
//   output register is free and the front cell is sent each time, leaving
//   the list in its original order.
//   Reset: the list is empty, no output is pending.
//   Stall: results sit in an output register; while it is held the chain
//   does not advance. A new item can be accepted while a result waits.

module bounded_list_with_key_delete_unit #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] key
	input  logic [2:0]  s_tuser,   // [2:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] entry_key
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	bld_pkg::fsm_t              state_q, state_d;
	bld_pkg::func_t             func_q;
	logic signed [31:0]         key_q;
	logic [CNT_W-1:0]           occ_q, occ_d;
	logic [CNT_W-1:0]           cnt_q, cnt_d;

	logic                       out_valid_q;
	logic [31:0]                out_key_q;
	logic [2:0]                 out_status_q;
	logic                       out_last_q;

	logic                       ofree;
	logic                       emit;
	bld_pkg::status_t           emit_status;
	logic [31:0]                emit_key;
	logic                       emit_last;

	bld_pkg::cell_ctl_t         ctl;
	logic                       hit_first;
	logic [CAPACITY:0]          hit;
	logic [CAPACITY-1:0]        valid_vec;
	logic [31:0]                key_vec [CAPACITY];
	logic                       empty, full, found, dump_last;

	assign ofree     = !out_valid_q || m_tready;
	assign empty     = (occ_q == '0);
	assign full      = (occ_q == CNT_W'(CAPACITY));
	assign hit[0]    = hit_first;
	assign found     = hit[CAPACITY];
	assign dump_last = ((cnt_q + CNT_W'(1)) == occ_q);

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] prev_key, next_key;
		logic        prev_valid, next_valid;
		if (i == 0) begin : g_front
			assign prev_key   = key_q;
			assign prev_valid = 1'b1;
		end else begin : g_mid
			assign prev_key   = key_vec[i-1];
			assign prev_valid = valid_vec[i-1];
		end
		if (i == CAPACITY - 1) begin : g_back
			assign next_key   = '0;
			assign next_valid = 1'b0;
		end else begin : g_inner
			assign next_key   = key_vec[i+1];
			assign next_valid = valid_vec[i+1];
		end
		bld_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_key   (prev_key),
			.prev_valid (prev_valid),
			.next_key   (next_key),
			.next_valid (next_valid),
			.front_key  (key_vec[0]),
			.hit_in     (hit[i]),
			.hit_out    (hit[i+1]),
			.key        (key_vec[i]),
			.valid      (valid_vec[i])
		);
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bld_pkg::S_IDLE;
			occ_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			cnt_q   <= cnt_d;
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= bld_pkg::func_t'(s_tuser);
			key_q  <= s_tdata;
		end
	end

	// next state, chain control and result
	always_comb begin
		state_d     = state_q;
		occ_d       = occ_q;
		cnt_d       = cnt_q;
		ctl.op      = bld_pkg::CELL_HOLD;
		ctl.key     = key_q;
		hit_first   = 1'b0;
		emit        = 1'b0;
		emit_status = bld_pkg::STS_OK;
		emit_key    = '0;
		emit_last   = 1'b1;
		s_tready    = (state_q == bld_pkg::S_IDLE);
		unique case (state_q)
			bld_pkg::S_IDLE: begin
				if (s_tvalid) state_d = bld_pkg::S_EXEC;
			end
			bld_pkg::S_EXEC: begin
				hit_first = (func_q == bld_pkg::FN_DEL_FIRST);
				if (ofree) begin
					emit    = 1'b1;
					state_d = bld_pkg::S_IDLE;
					case (func_q) inside
						bld_pkg::FN_INSERT: begin
							if (full) begin
								emit_status = bld_pkg::STS_FULL;
							end else begin
								ctl.op = bld_pkg::CELL_PUSH;
								occ_d  = occ_q + CNT_W'(1);
							end
						end
						bld_pkg::FN_DEL_KEY, bld_pkg::FN_DEL_FIRST: begin
							if (empty) begin
								emit_status = bld_pkg::STS_EMPTY;
							end else if (found) begin
								ctl.op = bld_pkg::CELL_REMOVE;
								occ_d  = occ_q - CNT_W'(1);
							end else begin
								emit_status = bld_pkg::STS_NOT_FOUND;
							end
						end
						bld_pkg::FN_DEL_LAST: begin
							if (empty) begin
								emit_status = bld_pkg::STS_EMPTY;
							end else begin
								ctl.op = bld_pkg::CELL_TRIM;
								occ_d  = occ_q - CNT_W'(1);
							end
						end
						bld_pkg::FN_DUMP: begin
							if (empty) begin
								emit_status = bld_pkg::STS_EMPTY;
							end else begin
								emit    = 1'b0;
								cnt_d   = '0;
								state_d = bld_pkg::S_DUMP;
							end
						end
						default: emit_status = bld_pkg::STS_OK;
					endcase
				end
			end
			bld_pkg::S_DUMP: begin
				if (ofree) begin
					emit        = 1'b1;
					emit_status = bld_pkg::STS_ENTRY;
					emit_key    = key_vec[0];
					emit_last   = dump_last;
					ctl.op      = bld_pkg::CELL_ROTATE;
					cnt_d       = cnt_q + CNT_W'(1);
					if (dump_last) state_d = bld_pkg::S_IDLE;
				end
			end
			default: state_d = bld_pkg::S_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ofree) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ofree && emit) begin
			out_key_q    <= emit_key;
			out_status_q <= emit_status;
			out_last_q   <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_key_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	// checks
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == occ_q)
		else $error("cell valid bits disagree with occupancy");

	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("gap in occupied cells");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bld_pkg::S_DUMP |-> occ_q != '0)
		else $error("dumping an empty list");

	a_dump_occ_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bld_pkg::S_DUMP && $past(state_q == bld_pkg::S_DUMP) |-> $stable(occ_q))
		else $error("occupancy changed during dump");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != bld_pkg::STS_ENTRY |-> m_tlast)
		else $error("status result not marked last");

endmodule

// ===== design/bld_cell.sv =====
// One list slot: holds a key and a valid bit, shifts toward either neighbor.
`timescale 1ns / 1ps

module bld_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bld_pkg::cell_ctl_t         ctl,
	input  logic [bld_pkg::KEY_W-1:0]  prev_key,
	input  logic                       prev_valid,
	input  logic [bld_pkg::KEY_W-1:0]  next_key,
	input  logic                       next_valid,
	input  logic [bld_pkg::KEY_W-1:0]  front_key,
	input  logic                       hit_in,
	output logic                       hit_out,
	output logic [bld_pkg::KEY_W-1:0]  key,
	output logic                       valid
);

	logic [bld_pkg::KEY_W-1:0] key_q;
	logic                      valid_q;
	logic                      match;

	// first-match search ripples from the front
	assign match   = valid_q && (key_q == ctl.key);
	assign hit_out = hit_in | match;

	// key storage, no reset needed
	always_ff @(posedge clk) begin
		case (ctl.op)
			bld_pkg::CELL_PUSH: key_q <= prev_key;
			bld_pkg::CELL_REMOVE: begin
				if (hit_out && next_valid) key_q <= next_key;
			end
			bld_pkg::CELL_ROTATE: begin
				if (valid_q) key_q <= next_valid ? next_key : front_key;
			end
			default: key_q <= key_q;
		endcase
	end

	// occupancy bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				bld_pkg::CELL_PUSH: valid_q <= prev_valid;
				bld_pkg::CELL_REMOVE: begin
					if (hit_out) valid_q <= next_valid;
				end
				bld_pkg::CELL_TRIM: valid_q <= valid_q & next_valid;
				default: valid_q <= valid_q;
			endcase
		end
	end

	assign key   = key_q;
	assign valid = valid_q;

endmodule
